// ===== rtl/bdq_pkg.sv =====
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int WORD_W = 32;
    localparam int ACT_W  = 3;

    localparam int IN_FIELD_W  = ACT_W + WORD_W;
    localparam int IN_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = 1 + WORD_W + WORD_W + 1 + 1;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

    localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INS_REAR  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DEL_FRONT = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DEL_REAR  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PEEK      = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // latch incoming request
        logic exec;     // apply the action to pointers and store
        logic rd;       // read front and rear entries
        logic load;     // fill the output register
    } t_bdq_cmd;

endpackage

// ===== rtl/bounded_double_ended_queue_core.sv =====
`timescale 1ns / 1ps

// Bounded deque of signed 32-bit words held in a 1024-entry ring (head pointer
// plus entry count). Each request carries one action (insert front/rear,
// delete front/rear, peek) and yields exactly one result: success, front and
// rear words after the action (all ones when empty), and empty/full flags.
// The request is latched at the edge it is accepted. The block then updates
// pointers and writes the ring, reads both ends of the ring, and loads the
// result into the output register. The next request is taken in the cycle
// after the result is loaded, even while that result waits on m_axis_tready,
// so no new request is taken before the previous result is loaded. A load
// waits while the previous result is still held.
// Capacity is written through the cfg channel; the user must write it only
// while idle, which the block itself does not enforce. Values above 1024 act
// as 1024, and zero refuses every insert. No clearing pass after reset.
module bounded_double_ended_queue_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config: capacity
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bdq_pkg::CNT_W-1:0]           i_cfg_data,
    // request
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [bdq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // action[2:0], value[34:3]
    // result
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [bdq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata   // success[0], front[32:1],
                                                               // rear[64:33], is_empty[65],
                                                               // is_full[66]
);
    import bdq_pkg::*;

    t_bdq_cmd cmd;

    assign o_cfg_ready = 1'b1;

    bdq_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_cmd         (cmd)
    );

    bdq_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (s_axis_tdata),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_out_data (m_axis_tdata)
    );

endmodule

// ===== rtl/bdq_ctrl.sv =====
`timescale 1ns / 1ps

module bdq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output bdq_pkg::t_bdq_cmd o_cmd
);
    import bdq_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign out_free      = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !m_axis_tready;
        o_cmd        = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_READ;
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_LOAD;
            end
            ST_LOAD: begin
                // wait here while the previous result is still held
                if (out_free) begin
                    o_cmd.load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/bdq_dp.sv =====
`timescale 1ns / 1ps

module bdq_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bdq_pkg::t_bdq_cmd                  i_cmd,
    input  logic [bdq_pkg::IN_TDATA_W-1:0]     i_in_data,
    input  logic                               i_cfg_we,
    input  logic [bdq_pkg::CNT_W-1:0]          i_cfg_data,
    output logic [bdq_pkg::OUT_TDATA_W-1:0]    o_out_data
);
    import bdq_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];

    logic [ACT_W-1:0]  r_action;
    logic [WORD_W-1:0] r_value;
    logic [ADDR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_cap;
    logic              r_ok, n_ok;
    logic [WORD_W-1:0] r_front_rd, r_rear_rd;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [CNT_W-1:0]  eff_cap;
    logic              full_now;
    logic              empty_now;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] rear_addr;
    logic [WORD_W-1:0] front_out, rear_out;

    // capacity above the built depth acts as the depth
    assign eff_cap   = (r_cap > CAP_RESET) ? CAP_RESET : r_cap;
    assign full_now  = (r_count >= eff_cap);
    assign empty_now = (r_count == '0);
    assign rear_addr = ADDR_W'(r_head + r_count[ADDR_W-1:0] - 1'b1);

    always_comb begin
        n_head = r_head;
        n_count = r_count;
        n_ok   = 1'b0;
        we     = 1'b0;
        waddr  = ADDR_W'(r_head + r_count[ADDR_W-1:0]);
        unique case (r_action)
            ACT_INS_FRONT: begin
                if (!full_now) begin
                    n_head  = ADDR_W'(r_head - 1'b1);
                    waddr   = ADDR_W'(r_head - 1'b1);
                    we      = 1'b1;
                    n_count = CNT_W'(r_count + 1'b1);
                    n_ok    = 1'b1;
                end
            end
            ACT_INS_REAR: begin
                if (!full_now) begin
                    we      = 1'b1;
                    n_count = CNT_W'(r_count + 1'b1);
                    n_ok    = 1'b1;
                end
            end
            ACT_DEL_FRONT: begin
                if (!empty_now) begin
                    n_head  = ADDR_W'(r_head + 1'b1);
                    n_count = CNT_W'(r_count - 1'b1);
                    n_ok    = 1'b1;
                end
            end
            ACT_DEL_REAR: begin
                if (!empty_now) begin
                    n_count = CNT_W'(r_count - 1'b1);
                    n_ok    = 1'b1;
                end
            end
            ACT_PEEK: n_ok = 1'b1;
            default:  n_ok = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && we) begin
            r_mem[waddr] <= r_value;
        end
        if (i_cmd.rd) begin
            r_front_rd <= r_mem[r_head];
            r_rear_rd  <= r_mem[rear_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_cap   <= CAP_RESET;
        end else begin
            if (i_cmd.exec) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    assign front_out = empty_now ? '1 : r_front_rd;
    assign rear_out  = empty_now ? '1 : r_rear_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action <= i_in_data[ACT_W-1:0];
            r_value  <= i_in_data[ACT_W +: WORD_W];
        end
        if (i_cmd.exec) begin
            r_ok <= n_ok;
        end
        if (i_cmd.load) begin
            r_out_data <= {(OUT_TDATA_W - OUT_FIELD_W)'(0), full_now, empty_now,
                           rear_out, front_out, r_ok};
        end
    end

    assign o_out_data = r_out_data;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import bdq_pkg::*;

    // opcodes outside the defined set; the block must refuse them
    localparam logic [ACT_W-1:0] ACT_RSVD_5 = 3'd5;
    localparam logic [ACT_W-1:0] ACT_RSVD_6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_RSVD_7 = 3'd7;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned MAX_PRINTS  = 40;

    typedef struct packed {
        logic              is_full;
        logic              is_empty;
        logic [WORD_W-1:0] rear;
        logic [WORD_W-1:0] front;
        logic              success;
    } t_deque_result;

    class deque_scoreboard;
        logic [WORD_W-1:0] ring [DEPTH];
        int unsigned       head;
        int unsigned       count;
        int unsigned       cap_eff;
        t_deque_result     expected_q [$];
        int unsigned       errors;

        function void reset();
            head    = 0;
            count   = 0;
            cap_eff = DEPTH;
            errors  = 0;
            expected_q.delete();
        endfunction

        function void set_capacity(logic [CNT_W-1:0] cap);
            cap_eff = (cap > DEPTH) ? DEPTH : cap;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // apply one request to the shadow deque and queue up its result
        function void note_request(logic [ACT_W-1:0] act, logic [WORD_W-1:0] val);
            t_deque_result r;
            logic          was_full;
            was_full  = (count >= cap_eff);
            r.success = 1'b0;
            case (act)
                ACT_INS_FRONT: begin
                    if (!was_full) begin
                        head       = (head + DEPTH - 1) % DEPTH;
                        ring[head] = val;
                        count++;
                        r.success = 1'b1;
                    end
                end
                ACT_INS_REAR: begin
                    if (!was_full) begin
                        ring[(head + count) % DEPTH] = val;
                        count++;
                        r.success = 1'b1;
                    end
                end
                ACT_DEL_FRONT: begin
                    if (count != 0) begin
                        head = (head + 1) % DEPTH;
                        count--;
                        r.success = 1'b1;
                    end
                end
                ACT_DEL_REAR: begin
                    if (count != 0) begin
                        count--;
                        r.success = 1'b1;
                    end
                end
                ACT_PEEK: begin
                    r.success = 1'b1;
                end
                default: ;
            endcase
            r.is_empty = (count == 0);
            r.is_full  = (count >= cap_eff);
            r.front    = (count == 0) ? '1 : ring[head];
            r.rear     = (count == 0) ? '1 : ring[(head + count - 1) % DEPTH];
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS)
                $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] bus);
            t_deque_result got;
            t_deque_result want;
            got = t_deque_result'(bus[OUT_FIELD_W-1:0]);
            if (expected_q.size() == 0) begin
                report("result with no request outstanding");
                return;
            end
            want = expected_q.pop_front();
            if (got.success !== want.success)
                report($sformatf("success got %b exp %b", got.success, want.success));
            if (got.front !== want.front)
                report($sformatf("front got %h exp %h", got.front, want.front));
            if (got.rear !== want.rear)
                report($sformatf("rear got %h exp %h", got.rear, want.rear));
            if (got.is_empty !== want.is_empty)
                report($sformatf("is_empty got %b exp %b", got.is_empty, want.is_empty));
            if (got.is_full !== want.is_full)
                report($sformatf("is_full got %b exp %b", got.is_full, want.is_full));
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CNT_W-1:0]       i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // action[2:0], value[34:3]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // success[0], front[32:1], rear[64:33],
                                            // is_empty[65], is_full[66]

    deque_scoreboard sb = new();
    int unsigned     n_taken = 0;
    int unsigned     recv_wait = 0;
    logic            recv_gaps;
    logic            hold_off;
    bit              send_gaps;

    bounded_double_ended_queue_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // requests are predicted at the edge they are taken
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            sb.note_request(s_axis_tdata[ACT_W-1:0], s_axis_tdata[ACT_W +: WORD_W]);
            n_taken++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
                recv_wait = recv_gaps ? $urandom_range(0, 5) : 0;
            end else if (recv_wait > 0) begin
                recv_wait--;
            end
            m_axis_tready <= !hold_off && (recv_wait == 0);
        end
    end

    // long back-pressure bursts; the sender keeps going so the input side stalls
    initial begin : receiver_hold
        int unsigned k;
        hold_off <= 1'b0;
        wait (n_taken >= 300);
        @(posedge i_clk);
        hold_off <= 1'b1;
        for (k = 0; k < 250; k++) @(posedge i_clk);
        hold_off <= 1'b0;
        wait (n_taken >= 1000);
        @(posedge i_clk);
        hold_off <= 1'b1;
        for (k = 0; k < 400; k++) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : watchdog
        int unsigned cyc;
        for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    task automatic send_item(logic [ACT_W-1:0] act, logic [WORD_W-1:0] val);
        int unsigned gap;
        gap = send_gaps ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - IN_FIELD_W){1'b0}}, val, act};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop offering and wait for every outstanding result, plus pipeline slack
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic configure(logic [CNT_W-1:0] cap);
        drain();
        i_cfg_data  <= cap;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_capacity(cap);
    endtask

    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // ins_pct of inserts, deletes up to 92 %, then peeks and bad opcodes
    function automatic logic [ACT_W-1:0] pick_action(int unsigned ins_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            return $urandom_range(0, 1) ? ACT_INS_FRONT : ACT_INS_REAR;
        if (r < 92)
            return $urandom_range(0, 1) ? ACT_DEL_FRONT : ACT_DEL_REAR;
        if (r < 96)
            return ACT_PEEK;
        case ($urandom_range(0, 2))
            0:       return ACT_RSVD_5;
            1:       return ACT_RSVD_6;
            default: return ACT_RSVD_7;
        endcase
    endfunction

    task automatic run_random(int unsigned n, int unsigned ins_pct, int unsigned pause_at);
        int unsigned i;
        send_gaps = ($urandom_range(0, 3) != 0);
        recv_gaps <= ($urandom_range(0, 3) != 0);
        for (i = 0; i < n; i++) begin
            if (i == pause_at)
                drain();
            send_item(pick_action(ins_pct), pick_value());
        end
    endtask

    initial begin : stimulus
        logic [CNT_W-1:0] small_caps [10];
        int unsigned      p;
        small_caps = '{11'd1, 11'd3, 11'd0, 11'd2, 11'd7, 11'd16, 11'd1025, 11'd5,
                       11'd1, 11'd12};
        sb.reset();
        send_gaps = 1'b0;
        recv_gaps     <= 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty deque: peeks, refused deletes, bad opcodes
        send_item(ACT_PEEK,      32'h0000_0000);
        send_item(ACT_DEL_FRONT, 32'h1234_5678);
        send_item(ACT_DEL_REAR,  32'h0000_0000);
        send_item(ACT_RSVD_5,    32'hFFFF_FFFF);
        // head wraps below zero on the first front insert
        send_item(ACT_INS_FRONT, 32'h7FFF_FFFF);
        send_item(ACT_INS_REAR,  32'h8000_0000);
        send_item(ACT_INS_FRONT, 32'hFFFF_FFFF);
        send_item(ACT_INS_REAR,  32'h0000_0000);
        send_item(ACT_RSVD_6,    32'h0000_0000);
        send_item(ACT_RSVD_7,    32'hA5A5_5A5A);
        send_item(ACT_PEEK,      32'h5A5A_A5A5);
        send_item(ACT_DEL_FRONT, 32'h0000_0000);
        send_item(ACT_DEL_REAR,  32'h0000_0000);
        send_item(ACT_DEL_FRONT, 32'h0000_0000);
        send_item(ACT_DEL_REAR,  32'h0000_0000);
        send_item(ACT_DEL_FRONT, 32'h0000_0000);

        // zero capacity: empty and full at once
        configure(11'd0);
        send_item(ACT_INS_FRONT, 32'h0000_0001);
        send_item(ACT_INS_REAR,  32'h0000_0002);
        send_item(ACT_PEEK,      32'h0000_0000);

        configure(11'd2);
        send_item(ACT_INS_REAR,  32'h1111_1111);
        send_item(ACT_INS_REAR,  32'h2222_2222);
        send_item(ACT_INS_FRONT, 32'h3333_3333);

        // capacity dropped below the held count: entries stay, inserts refused
        configure(11'd1);
        send_item(ACT_PEEK,      32'h0000_0000);
        send_item(ACT_INS_REAR,  32'h4444_4444);
        send_item(ACT_DEL_FRONT, 32'h0000_0000);
        send_item(ACT_INS_FRONT, 32'h5555_5555);
        send_item(ACT_DEL_REAR,  32'h0000_0000);
        send_item(ACT_INS_FRONT, 32'h6666_6666);

        for (p = 0; p < 10; p++) begin
            configure(small_caps[p]);
            run_random(45, (p % 2 == 0) ? 60 : 30, (p == 4) ? 20 : 1000);
        end

        // over-range capacity acts as the full ring; fill it and bang on full
        configure(11'd2047);
        run_random(1250, 90, 100000);
        configure(11'd1024);
        run_random(30, 30, 100000);
        configure(11'd1023);
        run_random(30, 40, 100000);

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
